### hw/rtl/kpm_pkg.sv
// Package for the keypad event to UTF-8 mapper: action codes, key codes,
// layout codes, the packed character type and the keymap lookup functions.
// Depends on nothing.
package kpm_pkg;

   localparam logic [2:0] ACT_KEY = 3'd0;
   localparam logic [2:0] ACT_POLL = 3'd1;
   localparam logic [2:0] ACT_SET_LAYOUT = 3'd2;
   localparam logic [2:0] ACT_SET_LOCK = 3'd3;
   localparam logic [2:0] ACT_CLEAR_MOD = 3'd4;

   localparam logic [6:0] KEY_ALT = 7'h14;
   localparam logic [6:0] KEY_CASE = 7'h1C;
   localparam logic [6:0] KEY_BKSP = 7'h1D;
   localparam logic [6:0] KEY_BLANK = 7'h1E;
   localparam logic [6:0] KEY_MAX = 7'd96;

   localparam logic [1:0] LAY_EN = 2'd0;
   localparam logic [1:0] LAY_PHON = 2'd1;
   localparam logic [1:0] LAY_STD = 2'd2;

   localparam logic [1:0] REG_LONG_PRESS = 2'd0;

   localparam logic [15:0] LONG_PRESS_RESET = 16'd700;

   localparam int MAP_ROWS = 4;
   localparam int MAP_COLS = 10;

   typedef struct packed {
      logic [1:0] len;
      logic [7:0] first;
      logic [7:0] second;
   } char_type;

   typedef struct packed {
      logic       caps;
      logic       alt;
      logic [1:0] layout;
      logic       lock;
      logic       layout_pulse;
      logic       lock_pulse;
   } status_type;

   function automatic logic [7:0] base_map(input logic [1:0] row, input logic [3:0] col);
      logic [7:0] r;
      r = 8'h00;
      case (row)
         2'd0: begin
            case (col)
               4'd0: r = "q"; 4'd1: r = "w"; 4'd2: r = "e"; 4'd3: r = "r";
               4'd4: r = "t"; 4'd5: r = "y"; 4'd6: r = "u"; 4'd7: r = "i";
               4'd8: r = "o"; 4'd9: r = "p"; default: r = 8'h00;
            endcase
         end
         2'd1: begin
            case (col)
               4'd0: r = "a"; 4'd1: r = "s"; 4'd2: r = "d"; 4'd3: r = "f";
               4'd4: r = "g"; 4'd5: r = "h"; 4'd6: r = "j"; 4'd7: r = "k";
               4'd8: r = "l"; 4'd9: r = 8'h0A; default: r = 8'h00;
            endcase
         end
         2'd2: begin
            case (col)
               4'd1: r = "z"; 4'd2: r = "x"; 4'd3: r = "c"; 4'd4: r = "v";
               4'd5: r = "b"; 4'd6: r = "n"; 4'd7: r = "m"; default: r = 8'h00;
            endcase
         end
         default: r = (col == 4'd0) ? 8'h20 : 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] sym_map(input logic [1:0] row, input logic [3:0] col);
      logic [7:0] r;
      r = 8'h00;
      case (row)
         2'd0: begin
            case (col)
               4'd0: r = "1"; 4'd1: r = "2"; 4'd2: r = "3"; 4'd3: r = "4";
               4'd4: r = "5"; 4'd5: r = "6"; 4'd6: r = "7"; 4'd7: r = "8";
               4'd8: r = "9"; 4'd9: r = "0"; default: r = 8'h00;
            endcase
         end
         2'd1: begin
            case (col)
               4'd0: r = "*"; 4'd1: r = "/"; 4'd2: r = "+"; 4'd3: r = "-";
               4'd4: r = "="; 4'd5: r = ":"; 4'd6: r = 8'h27; 4'd7: r = 8'h22;
               4'd8: r = "@"; default: r = 8'h00;
            endcase
         end
         2'd2: begin
            case (col)
               4'd1: r = "_"; 4'd2: r = "$"; 4'd3: r = ";"; 4'd4: r = "?";
               4'd5: r = "!"; 4'd6: r = ","; 4'd7: r = "."; default: r = 8'h00;
            endcase
         end
         default: r = (col == 4'd0) ? 8'h20 : 8'h00;
      endcase
      return r;
   endfunction

   // Cyrillic letter as a two-byte UTF-8 code; lower and upper case are both tabled below.
   function automatic logic [15:0] cyr_letter(input logic std, input logic up,
                                              input logic [4:0] i);
      logic [15:0] lo;
      logic [15:0] hi;
      lo = 16'h0;
      hi = 16'h0;
      if (!std) begin
         case (i)
            5'd0: begin lo = 16'hD0B0; hi = 16'hD090; end
            5'd1: begin lo = 16'hD0B1; hi = 16'hD091; end
            5'd2: begin lo = 16'hD186; hi = 16'hD0A6; end
            5'd3: begin lo = 16'hD0B4; hi = 16'hD094; end
            5'd4: begin lo = 16'hD0B5; hi = 16'hD095; end
            5'd5: begin lo = 16'hD184; hi = 16'hD0A4; end
            5'd6: begin lo = 16'hD0B3; hi = 16'hD093; end
            5'd7: begin lo = 16'hD187; hi = 16'hD0A7; end
            5'd8: begin lo = 16'hD0B8; hi = 16'hD098; end
            5'd9: begin lo = 16'hD0B9; hi = 16'hD099; end
            5'd10: begin lo = 16'hD0BA; hi = 16'hD09A; end
            5'd11: begin lo = 16'hD0BB; hi = 16'hD09B; end
            5'd12: begin lo = 16'hD0BC; hi = 16'hD09C; end
            5'd13: begin lo = 16'hD0BD; hi = 16'hD09D; end
            5'd14: begin lo = 16'hD0BE; hi = 16'hD09E; end
            5'd15: begin lo = 16'hD0BF; hi = 16'hD09F; end
            5'd16: begin lo = 16'hD18F; hi = 16'hD0AF; end
            5'd17: begin lo = 16'hD180; hi = 16'hD0A0; end
            5'd18: begin lo = 16'hD181; hi = 16'hD0A1; end
            5'd19: begin lo = 16'hD182; hi = 16'hD0A2; end
            5'd20: begin lo = 16'hD183; hi = 16'hD0A3; end
            5'd21: begin lo = 16'hD0B2; hi = 16'hD092; end
            5'd22: begin lo = 16'hD188; hi = 16'hD0A8; end
            5'd23: begin lo = 16'hD185; hi = 16'hD0A5; end
            5'd24: begin lo = 16'hD18B; hi = 16'hD0AB; end
            default: begin lo = 16'hD0B7; hi = 16'hD097; end
         endcase
      end else begin
         case (i)
            5'd0: begin lo = 16'hD184; hi = 16'hD0A4; end
            5'd1: begin lo = 16'hD0B8; hi = 16'hD098; end
            5'd2: begin lo = 16'hD181; hi = 16'hD0A1; end
            5'd3: begin lo = 16'hD0B2; hi = 16'hD092; end
            5'd4: begin lo = 16'hD183; hi = 16'hD0A3; end
            5'd5: begin lo = 16'hD0B0; hi = 16'hD090; end
            5'd6: begin lo = 16'hD0BF; hi = 16'hD09F; end
            5'd7: begin lo = 16'hD180; hi = 16'hD0A0; end
            5'd8: begin lo = 16'hD188; hi = 16'hD0A8; end
            5'd9: begin lo = 16'hD0BE; hi = 16'hD09E; end
            5'd10: begin lo = 16'hD0BB; hi = 16'hD09B; end
            5'd11: begin lo = 16'hD0B4; hi = 16'hD094; end
            5'd12: begin lo = 16'hD18C; hi = 16'hD0AC; end
            5'd13: begin lo = 16'hD182; hi = 16'hD0A2; end
            5'd14: begin lo = 16'hD189; hi = 16'hD0A9; end
            5'd15: begin lo = 16'hD0B7; hi = 16'hD097; end
            5'd16: begin lo = 16'hD0B9; hi = 16'hD099; end
            5'd17: begin lo = 16'hD0BA; hi = 16'hD09A; end
            5'd18: begin lo = 16'hD18B; hi = 16'hD0AB; end
            5'd19: begin lo = 16'hD0B5; hi = 16'hD095; end
            5'd20: begin lo = 16'hD0B3; hi = 16'hD093; end
            5'd21: begin lo = 16'hD0BC; hi = 16'hD09C; end
            5'd22: begin lo = 16'hD186; hi = 16'hD0A6; end
            5'd23: begin lo = 16'hD187; hi = 16'hD0A7; end
            5'd24: begin lo = 16'hD0BD; hi = 16'hD09D; end
            default: begin lo = 16'hD18F; hi = 16'hD0AF; end
         endcase
      end
      return up ? hi : lo;
   endfunction

   // Extra Cyrillic letters on the symbol layer; zero means none.
   function automatic logic [15:0] ru_extra(input logic [1:0] lay, input logic up,
                                            input logic [7:0] sc);
      logic [15:0] lo;
      logic [15:0] hi;
      lo = 16'h0;
      hi = 16'h0;
      if (lay == LAY_PHON) begin
         case (sc)
            "-": begin lo = 16'hD18C; hi = 16'hD0AC; end
            "=": begin lo = 16'hD18A; hi = 16'hD0AA; end
            8'h27: begin lo = 16'hD18D; hi = 16'hD0AD; end
            ";": begin lo = 16'hD0B6; hi = 16'hD096; end
            "$": begin lo = 16'hD18E; hi = 16'hD0AE; end
            "_": begin lo = 16'hD189; hi = 16'hD0A9; end
            "!": begin lo = 16'hD191; hi = 16'hD081; end
            default: begin lo = 16'h0; hi = 16'h0; end
         endcase
      end else if (lay == LAY_STD) begin
         case (sc)
            ";": begin lo = 16'hD0B6; hi = 16'hD096; end
            8'h27: begin lo = 16'hD18D; hi = 16'hD0AD; end
            ",": begin lo = 16'hD0B1; hi = 16'hD091; end
            ".": begin lo = 16'hD18E; hi = 16'hD0AE; end
            "$": begin lo = 16'hD185; hi = 16'hD0A5; end
            "_": begin lo = 16'hD18A; hi = 16'hD0AA; end
            "!": begin lo = 16'hD191; hi = 16'hD081; end
            default: begin lo = 16'h0; hi = 16'h0; end
         endcase
      end
      return up ? hi : lo;
   endfunction

endpackage

### hw/rtl/kpm_char_map.sv
// Character lookup for one key press: maps row and column through the
// letter or symbol keymaps to no character, one ASCII byte or a two-byte UTF-8 character.
// Depends on kpm_pkg.
module kpm_char_map (
   input  logic [1:0]       row,
   input  logic [3:0]       col,
   input  logic             in_map,
   input  logic             alt,
   input  logic             caps,
   input  logic [1:0]       layout,
   output kpm_pkg::char_type char_out
);
   logic [7:0]  base_c;
   logic [7:0]  sym_c;
   logic [15:0] extra;
   logic [7:0]  letter_idx;

   assign base_c = kpm_pkg::base_map(row, col);
   assign sym_c = kpm_pkg::sym_map(row, col);
   assign extra = kpm_pkg::ru_extra(layout, caps, sym_c);
   assign letter_idx = base_c - 8'h61;

   always_comb begin
      char_out = '0;
      if (in_map) begin
         if (alt) begin
            if (sym_c != 8'h00) begin
               if (extra != 16'h0) begin
                  char_out = '{len: 2'd2, first: extra[15:8], second: extra[7:0]};
               end else begin
                  char_out = '{len: 2'd1, first: sym_c, second: 8'h00};
               end
            end
         end else if (base_c != 8'h00) begin
            if (base_c >= 8'h61 && base_c <= 8'h7A) begin
               if (layout == kpm_pkg::LAY_PHON || layout == kpm_pkg::LAY_STD) begin
                  char_out.len = 2'd2;
                  {char_out.first, char_out.second} = kpm_pkg::cyr_letter(
                     layout == kpm_pkg::LAY_STD, caps, letter_idx[4:0]);
               end else begin
                  char_out = '{len: 2'd1, first: caps ? base_c - 8'd32 : base_c,
                               second: 8'h00};
               end
            end else begin
               char_out = '{len: 2'd1, first: base_c, second: 8'h00};
            end
         end
      end
   end
endmodule

### hw/rtl/keypad_event_to_utf8_mapper_unit.sv
// Keypad event to UTF-8 mapper, top level. Depends on kpm_pkg and kpm_char_map.
//
// Each req_ transaction carries one action (key event, empty poll, set layout,
// set lock, clear modifiers) with a millisecond time stamp, and yields exactly
// one rsp_ transaction with the produced character (zero, one or two UTF-8
// bytes) and the modifier, layout and lock state after that action. An item is
// captured in an input register, handled by one pass of short logic that also
// updates the modifier state, and lands in a result register. A new transaction
// is accepted every cycle unless the pipeline stalls; the input register and
// result register act as a two-stage pipeline that stalls as a whole only when
// the result is still held and the input stage is full. The CAPS hold time
// that toggles the lock is set by register long_press_ms at address 0.
module keypad_event_to_utf8_mapper_unit #(
   parameter int KEY_ROWS = 4,
   parameter int KEY_COLS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_event_byte,
   input  logic [31:0] req_now_ms,
   input  logic [1:0]  req_new_layout,
   input  logic        req_lock_on,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_char_length,
   output logic [7:0]  rsp_char_first,
   output logic [7:0]  rsp_char_second,
   output logic        rsp_caps_on,
   output logic        rsp_alt_on,
   output logic [1:0]  rsp_layout_now,
   output logic        rsp_locked_now,
   output logic        rsp_layout_pulse,
   output logic        rsp_lock_pulse,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int ROW_LIMIT = (KEY_ROWS < kpm_pkg::MAP_ROWS) ? KEY_ROWS : kpm_pkg::MAP_ROWS;

   // Configuration register.
   logic [15:0] long_press_ff, long_press_in;
   assign csr_pready = 1'b1;
   assign long_press_in = (csr_psel && csr_penable && csr_pwrite
                           && csr_paddr == kpm_pkg::REG_LONG_PRESS)
                          ? csr_pwdata[15:0] : long_press_ff;
   assign csr_prdata = (csr_paddr == kpm_pkg::REG_LONG_PRESS) ? {16'h0, long_press_ff}
                                                               : 32'h0;

   // Input stage.
   logic        in_vld_ff;
   logic [2:0]  act_ff;
   logic [7:0]  ev_ff;
   logic [31:0] now_ff;
   logic [1:0]  lay_ff;
   logic        lk_ff;
   logic        adv;

   // The pass fires when the input stage is full and the result stage is free.
   assign adv = in_vld_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_vld_ff && !adv;

   // Block state.
   logic        caps_ff, caps_in, alt_ff, alt_in, lock_ff, lock_in;
   logic [1:0]  layout_ff, layout_in;
   logic        cdv_ff, cdv_in, fired_ff, fired_in;
   logic [31:0] cdt_ff, cdt_in;
   logic        pl, pk;

   logic        pressed;
   logic [6:0]  knum;
   logic [6:0]  k;
   logic        kvalid;
   logic [31:0] held;
   logic [1:0]  lay_req;
   logic [1:0]  lay_next;
   logic [1:0]  row;
   logic [3:0]  col;
   logic        in_map;
   logic [2:0]  row_full;
   logic [6:0]  col_full;
   kpm_pkg::char_type map_char, ch;

   assign pressed = ev_ff[7];
   assign knum = ev_ff[6:0];
   assign kvalid = knum != 7'd0 && knum <= kpm_pkg::KEY_MAX;
   assign k = knum - 7'd1;
   assign held = cdv_ff ? (now_ff - cdt_ff) : 32'h0;
   assign lay_req = (lay_ff == 2'd3) ? kpm_pkg::LAY_EN : lay_ff;
   assign lay_next = (layout_ff == kpm_pkg::LAY_STD) ? kpm_pkg::LAY_EN : layout_ff + 2'd1;

   // Row and column by comparing the key number against the row boundaries.
   // Only the four map rows matter; anything beyond them is row four.
   always_comb begin
      if (k < 7'(KEY_COLS)) begin
         row_full = 3'd0;
         col_full = k;
      end else if (k < 7'(2 * KEY_COLS)) begin
         row_full = 3'd1;
         col_full = k - 7'(KEY_COLS);
      end else if (k < 7'(3 * KEY_COLS)) begin
         row_full = 3'd2;
         col_full = k - 7'(2 * KEY_COLS);
      end else if (k < 7'(4 * KEY_COLS)) begin
         row_full = 3'd3;
         col_full = k - 7'(3 * KEY_COLS);
      end else begin
         row_full = 3'd4;
         col_full = 7'd0;
      end
   end

   assign row = row_full[1:0];
   assign col = col_full[3:0];
   assign in_map = row_full < 3'(ROW_LIMIT) && col_full < 7'(kpm_pkg::MAP_COLS);

   kpm_char_map u_map (
      .row(row), .col(col), .in_map(in_map), .alt(alt_ff), .caps(caps_ff),
      .layout(layout_ff), .char_out(map_char)
   );

   always_comb begin
      caps_in = caps_ff;
      alt_in = alt_ff;
      lock_in = lock_ff;
      layout_in = layout_ff;
      cdv_in = cdv_ff;
      cdt_in = cdt_ff;
      fired_in = fired_ff;
      pl = 1'b0;
      pk = 1'b0;
      ch = '0;
      if (adv) begin
         case (act_ff)
            kpm_pkg::ACT_KEY: begin
               if (kvalid) begin
                  if (k == kpm_pkg::KEY_ALT) begin
                     if (!lock_ff) alt_in = pressed;
                  end else if (k == kpm_pkg::KEY_CASE) begin
                     if (pressed) begin
                        cdv_in = 1'b1;
                        cdt_in = now_ff;
                        fired_in = 1'b0;
                     end else begin
                        cdv_in = 1'b0;
                        if (fired_ff) begin
                           fired_in = 1'b0;
                        end else if (!lock_ff) begin
                           if (alt_ff) begin
                              layout_in = lay_next;
                              pl = 1'b1;
                           end else if (held < {16'h0, long_press_ff}) begin
                              caps_in = !caps_ff;
                           end
                        end
                     end
                  end else if (!lock_ff) begin
                     if (k == kpm_pkg::KEY_BKSP) begin
                        if (pressed) ch = '{len: 2'd1, first: alt_ff ? 8'h1B : 8'h08,
                                            second: 8'h00};
                     end else if (k == kpm_pkg::KEY_BLANK) begin
                        if (pressed) ch = '{len: 2'd1, first: 8'h20, second: 8'h00};
                     end else if (pressed) begin
                        ch = map_char;
                     end
                  end
               end
            end
            kpm_pkg::ACT_POLL: begin
               if (cdv_ff && !fired_ff && (now_ff - cdt_ff) >= {16'h0, long_press_ff}) begin
                  fired_in = 1'b1;
                  lock_in = !lock_ff;
                  pk = 1'b1;
                  if (!lock_ff) begin
                     caps_in = 1'b0;
                     alt_in = 1'b0;
                  end
               end
            end
            kpm_pkg::ACT_SET_LAYOUT: begin
               if (lay_req != layout_ff) begin
                  layout_in = lay_req;
                  pl = 1'b1;
               end
            end
            kpm_pkg::ACT_SET_LOCK: begin
               if (lk_ff != lock_ff) begin
                  lock_in = lk_ff;
                  pk = 1'b1;
                  if (lk_ff) begin
                     caps_in = 1'b0;
                     alt_in = 1'b0;
                  end
               end
            end
            kpm_pkg::ACT_CLEAR_MOD: begin
               caps_in = 1'b0;
               alt_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= kpm_pkg::LONG_PRESS_RESET;
         in_vld_ff <= 1'b0;
         rsp_valid <= 1'b0;
         caps_ff <= 1'b0;
         alt_ff <= 1'b0;
         lock_ff <= 1'b0;
         layout_ff <= kpm_pkg::LAY_EN;
         cdv_ff <= 1'b0;
         cdt_ff <= 32'h0;
         fired_ff <= 1'b0;
      end else begin
         long_press_ff <= long_press_in;
         if (req_valid && !req_stall) in_vld_ff <= 1'b1;
         else if (adv) in_vld_ff <= 1'b0;
         if (adv) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         caps_ff <= caps_in;
         alt_ff <= alt_in;
         lock_ff <= lock_in;
         layout_ff <= layout_in;
         cdv_ff <= cdv_in;
         cdt_ff <= cdt_in;
         fired_ff <= fired_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         act_ff <= req_action;
         ev_ff <= req_event_byte;
         now_ff <= req_now_ms;
         lay_ff <= req_new_layout;
         lk_ff <= req_lock_on;
      end
      if (adv) begin
         rsp_char_length <= ch.len;
         rsp_char_first <= ch.first;
         rsp_char_second <= ch.second;
         rsp_caps_on <= caps_in;
         rsp_alt_on <= alt_in;
         rsp_layout_now <= layout_in;
         rsp_locked_now <= lock_in;
         rsp_layout_pulse <= pl;
         rsp_lock_pulse <= pk;
      end
   end

   a_layout_range: assert property (@(posedge clock) disable iff (reset)
      layout_ff != 2'd3) else $error("layout register out of range");
   a_lock_clears: assert property (@(posedge clock) disable iff (reset)
      adv && lock_in |=> !caps_ff && !alt_ff) else $error("modifiers set while locked");
   a_no_adv_empty: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> !adv) else $error("pass fired without an item");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && !adv |=> rsp_valid) else $error("result lost");
endmodule
